[hdl/plcm_pkg.sv]
`timescale 1ns / 1ps
// Types and constants shared by the piecewise-linear color mapper.
// No dependencies.
package plcm_pkg;

    localparam int DIV_W = 42;
    localparam int DEN_W = 33;
    localparam logic [7:0] RGB_FULL = 8'd255;

    typedef enum logic [1:0] {
        MODE_SCAN = 2'd0,
        MODE_MAP  = 2'd1,
        MODE_LOAD = 2'd2,
        MODE_IDLE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_RESOLUTION  = 2'd0,
        CFG_MODULUS     = 2'd1,
        CFG_POINT_COUNT = 2'd2,
        CFG_NONE        = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] sample;
        logic               sample_finite;
        logic               frame_start;
        logic [3:0]         entry_index;
        logic [7:0]         entry_red;
        logic [7:0]         entry_green;
        logic [7:0]         entry_blue;
    } in_word_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       no_depth;
    } out_word_t;

    function automatic logic [DIV_W-1:0] mag42(input logic signed [DIV_W-1:0] a);
        mag42 = a[DIV_W-1] ? DIV_W'(-a) : DIV_W'(a);
    endfunction

endpackage

[hdl/piecewise_linear_color_mapper_top.sv]
`timescale 1ns / 1ps
// Piecewise-linear color mapper: sequencer, shared floor divider, palette memory.
// Depends on plcm_pkg.
//
// Scan and load words are taken in the idle state without stalling the input.
// A map word runs up to nine floor divisions, in order, on one shared
// radix-2 divider (42 quotient bits, then a sign fix and a sequencing step).
// Palette reads pass through ST_RD0, ST_NXT and ST_RD1, and each channel
// handoff passes through ST_RD1 again. A word past the last segment skips
// the channel divisions, and a range with no depth ends after the span or
// segment-length division. The input stalls for the whole of a map word; a
// finished result waits in the output register while the next word is taken.
module piecewise_linear_color_mapper_top #(
    parameter int MAX_POINTS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  plcm_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output plcm_pkg::out_word_t out_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [30:0]         cfg_data
);
    import plcm_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_FIX, ST_POST, ST_RD0, ST_NXT, ST_RD1, ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        SP_MOD, SP_LO, SP_HI, SP_SEGLEN, SP_VAL, SP_SEG, SP_CH
    } step_t;

    state_t state_reg;
    step_t  step_reg;

    logic [30:0] resolution_reg, modulus_reg;
    logic [4:0]  point_count_reg;
    logic signed [31:0] rmin_reg, rmax_reg;

    logic [DEN_W-1:0]   dv_rem_reg, dv_den_reg;
    logic [DIV_W-1:0]   dv_quo_reg;
    logic               dv_neg_reg;
    logic [5:0]         dv_cnt_reg;
    logic signed [DIV_W:0] fq_reg;
    logic [DEN_W-1:0]   fr_reg;

    logic signed [31:0] v_reg, hi_reg;
    logic [30:0]        res_reg;
    logic [4:0]         segs_reg;
    logic signed [33:0] minq_reg;
    logic [32:0]        span_reg, seglen_reg;
    logic [37:0]        rs_reg;
    logic [AW-1:0]      seg_addr_reg;
    logic               seg_hit_reg;
    logic [23:0]        base_reg, nxt_reg;
    logic [1:0]         ch_reg;
    logic [7:0]         col_reg [3];
    logic               nd_reg;
    out_word_t          out_reg;
    logic               out_valid_reg;

    logic [23:0] pal_mem [MAX_POINTS];
    logic [23:0] pal_rd_reg;
    logic [AW-1:0] rd_addr;

    logic [DEN_W:0]   rem_sh;
    logic             rem_ge;
    logic signed [DIV_W:0] span_w, val_w;
    logic [4:0]       n_sat;
    logic             seg_lt;
    logic signed [8:0] len_w;
    logic signed [47:0] prod_w;
    logic signed [9:0] c_w;
    logic [9:0]        c_abs;
    logic             pal_wr;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;
    assign cfg_ready = 1'b1;

    assign rem_sh = {dv_rem_reg, dv_quo_reg[DIV_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, dv_den_reg});
    assign span_w = fq_reg - (DIV_W+1)'(minq_reg);
    assign val_w  = fq_reg - (DIV_W+1)'(minq_reg);
    assign seg_lt = ($unsigned(fq_reg) < (DIV_W+1)'(segs_reg));

    always_comb
    begin
        if (point_count_reg < 5'd2)
            n_sat = 5'd2;
        else if (32'(point_count_reg) > 32'(MAX_POINTS))
            n_sat = 5'(MAX_POINTS);
        else
            n_sat = point_count_reg;
    end

    always_comb
    begin
        unique case (ch_reg)
            2'd0:    len_w = $signed({1'b0, nxt_reg[23:16]}) - $signed({1'b0, base_reg[23:16]});
            2'd1:    len_w = $signed({1'b0, nxt_reg[15:8]}) - $signed({1'b0, base_reg[15:8]});
            default: len_w = $signed({1'b0, nxt_reg[7:0]}) - $signed({1'b0, base_reg[7:0]});
        endcase
        prod_w = $signed({10'd0, rs_reg}) * 48'(len_w);
        unique case (ch_reg)
            2'd0:    c_w = $signed({2'b0, base_reg[23:16]}) + 10'(fq_reg);
            2'd1:    c_w = $signed({2'b0, base_reg[15:8]}) + 10'(fq_reg);
            default: c_w = $signed({2'b0, base_reg[7:0]}) + 10'(fq_reg);
        endcase
        c_abs = c_w[9] ? 10'(-c_w) : 10'(c_w);
    end

    always_comb
    begin
        priority if (state_reg == ST_POST && step_reg == SP_SEG)
            rd_addr = seg_lt ? AW'(fq_reg) : AW'(segs_reg);
        else if (state_reg == ST_RD0)
            rd_addr = seg_addr_reg + AW'(1);
        else
            rd_addr = '0;
    end

    assign pal_wr = (state_reg == ST_IDLE) && in_valid && (in_word.mode == MODE_LOAD)
                    && (32'(in_word.entry_index) < 32'(MAX_POINTS));

    always_ff @(posedge clk)
    begin
        if (pal_wr)
            pal_mem[AW'(in_word.entry_index)] <= {in_word.entry_red, in_word.entry_green,
                                                  in_word.entry_blue};
        pal_rd_reg <= pal_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= SP_MOD;
            resolution_reg  <= 31'd655;
            modulus_reg     <= '0;
            point_count_reg <= 5'd4;
            rmin_reg        <= '0;
            rmax_reg        <= '0;
            dv_rem_reg      <= '0;
            dv_den_reg      <= '0;
            dv_quo_reg      <= '0;
            dv_neg_reg      <= 1'b0;
            dv_cnt_reg      <= '0;
            fq_reg          <= '0;
            fr_reg          <= '0;
            v_reg           <= '0;
            hi_reg          <= '0;
            res_reg         <= '0;
            segs_reg        <= '0;
            minq_reg        <= '0;
            span_reg        <= '0;
            seglen_reg      <= '0;
            rs_reg          <= '0;
            seg_addr_reg    <= '0;
            seg_hit_reg     <= 1'b0;
            base_reg        <= '0;
            nxt_reg         <= '0;
            ch_reg          <= '0;
            col_reg         <= '{default: '0};
            nd_reg          <= 1'b0;
            out_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != ST_DONE)
                out_valid_reg <= 1'b0;

            if (cfg_valid)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_RESOLUTION:  resolution_reg  <= cfg_data;
                    CFG_MODULUS:     modulus_reg     <= cfg_data;
                    CFG_POINT_COUNT: point_count_reg <= cfg_data[4:0];
                    default:         ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && in_word.mode == MODE_SCAN)
                    begin
                        if (in_word.sample_finite)
                        begin
                            if (in_word.frame_start)
                            begin
                                rmax_reg <= (in_word.sample > 0) ? in_word.sample : '0;
                                rmin_reg <= (in_word.sample < 0) ? in_word.sample : '0;
                            end
                            else
                            begin
                                if (in_word.sample > rmax_reg)
                                    rmax_reg <= in_word.sample;
                                if (in_word.sample < rmin_reg)
                                    rmin_reg <= in_word.sample;
                            end
                        end
                        else if (in_word.frame_start)
                        begin
                            rmax_reg <= '0;
                            rmin_reg <= '0;
                        end
                    end
                    else if (in_valid && in_word.mode == MODE_MAP)
                    begin
                        res_reg    <= (resolution_reg == '0) ? 31'd1 : resolution_reg;
                        segs_reg   <= n_sat - 5'd1;
                        dv_rem_reg <= '0;
                        dv_cnt_reg <= 6'(DIV_W - 1);
                        state_reg  <= ST_DIV;
                        if (modulus_reg != '0)
                        begin
                            v_reg      <= in_word.sample_finite ? in_word.sample : '0;
                            hi_reg     <= $signed({1'b0, modulus_reg});
                            dv_quo_reg <= mag42(in_word.sample_finite ?
                                                DIV_W'(in_word.sample) : '0);
                            dv_neg_reg <= in_word.sample_finite && in_word.sample[31];
                            dv_den_reg <= DEN_W'(modulus_reg);
                            step_reg   <= SP_MOD;
                        end
                        else
                        begin
                            v_reg      <= in_word.sample_finite ? in_word.sample : '0;
                            hi_reg     <= rmax_reg;
                            dv_quo_reg <= mag42(DIV_W'(rmin_reg));
                            dv_neg_reg <= rmin_reg[31];
                            dv_den_reg <= DEN_W'((resolution_reg == '0) ? 31'd1
                                                                        : resolution_reg);
                            step_reg   <= SP_LO;
                        end
                    end
                end

                ST_DIV:
                begin
                    dv_rem_reg <= rem_ge ? DEN_W'(rem_sh - {1'b0, dv_den_reg})
                                         : rem_sh[DEN_W-1:0];
                    dv_quo_reg <= {dv_quo_reg[DIV_W-2:0], rem_ge};
                    dv_cnt_reg <= dv_cnt_reg - 6'd1;
                    if (dv_cnt_reg == '0)
                        state_reg <= ST_FIX;
                end

                ST_FIX:
                begin
                    if (dv_neg_reg && dv_rem_reg != '0)
                    begin
                        fq_reg <= -$signed({1'b0, dv_quo_reg}) - 1;
                        fr_reg <= dv_den_reg - dv_rem_reg;
                    end
                    else
                    begin
                        fq_reg <= dv_neg_reg ? -$signed({1'b0, dv_quo_reg})
                                             : $signed({1'b0, dv_quo_reg});
                        fr_reg <= dv_rem_reg;
                    end
                    state_reg <= ST_POST;
                end

                ST_POST:
                begin
                    dv_rem_reg <= '0;
                    dv_cnt_reg <= 6'(DIV_W - 1);
                    unique case (step_reg)
                        SP_MOD:
                        begin
                            v_reg      <= $signed(32'(fr_reg));
                            dv_quo_reg <= '0;
                            dv_neg_reg <= 1'b0;
                            dv_den_reg <= DEN_W'(res_reg);
                            step_reg   <= SP_LO;
                            state_reg  <= ST_DIV;
                        end
                        SP_LO:
                        begin
                            minq_reg   <= 34'(fq_reg);
                            dv_quo_reg <= mag42(DIV_W'(hi_reg));
                            dv_neg_reg <= hi_reg[31];
                            dv_den_reg <= DEN_W'(res_reg);
                            step_reg   <= SP_HI;
                            state_reg  <= ST_DIV;
                        end
                        SP_HI:
                        begin
                            span_reg   <= 33'(span_w);
                            dv_quo_reg <= DIV_W'(span_w);
                            dv_neg_reg <= 1'b0;
                            dv_den_reg <= DEN_W'(segs_reg);
                            step_reg   <= SP_SEGLEN;
                            if (span_w <= 0)
                            begin
                                nd_reg    <= 1'b1;
                                col_reg   <= '{default: '0};
                                state_reg <= ST_DONE;
                            end
                            else
                                state_reg <= ST_DIV;
                        end
                        SP_SEGLEN:
                        begin
                            seglen_reg <= 33'(fq_reg);
                            dv_quo_reg <= mag42(DIV_W'(v_reg));
                            dv_neg_reg <= v_reg[31];
                            dv_den_reg <= DEN_W'(res_reg);
                            step_reg   <= SP_VAL;
                            if (fq_reg == '0)
                            begin
                                nd_reg    <= 1'b1;
                                col_reg   <= '{default: '0};
                                state_reg <= ST_DONE;
                            end
                            else
                                state_reg <= ST_DIV;
                        end
                        SP_VAL:
                        begin
                            dv_neg_reg <= 1'b0;
                            dv_den_reg <= seglen_reg;
                            priority if (val_w < 0)
                                dv_quo_reg <= '0;
                            else if (val_w > (DIV_W+1)'(span_reg))
                                dv_quo_reg <= DIV_W'(span_reg);
                            else
                                dv_quo_reg <= DIV_W'(val_w);
                            step_reg  <= SP_SEG;
                            state_reg <= ST_DIV;
                        end
                        SP_SEG:
                        begin
                            seg_hit_reg  <= seg_lt;
                            seg_addr_reg <= rd_addr;
                            rs_reg       <= 38'(fr_reg) * 38'(segs_reg);
                            state_reg    <= ST_RD0;
                        end
                        default:
                        begin
                            col_reg[ch_reg] <= (c_abs > 10'(RGB_FULL)) ? RGB_FULL : c_abs[7:0];
                            dv_quo_reg      <= '0;
                            dv_neg_reg      <= 1'b0;
                            dv_den_reg      <= span_reg;
                            if (ch_reg == 2'd2)
                            begin
                                nd_reg    <= 1'b0;
                                state_reg <= ST_DONE;
                            end
                            else
                            begin
                                ch_reg    <= ch_reg + 2'd1;
                                state_reg <= ST_RD1;
                            end
                        end
                    endcase
                end

                ST_RD0:
                begin
                    base_reg  <= pal_rd_reg;
                    ch_reg    <= '0;
                    state_reg <= ST_NXT;
                end

                ST_NXT:
                begin
                    nxt_reg   <= pal_rd_reg;
                    state_reg <= ST_RD1;
                end

                ST_RD1:
                begin
                    if (!seg_hit_reg)
                    begin
                        col_reg[0] <= base_reg[23:16];
                        col_reg[1] <= base_reg[15:8];
                        col_reg[2] <= base_reg[7:0];
                        nd_reg     <= 1'b0;
                        state_reg  <= ST_DONE;
                    end
                    else
                    begin
                        step_reg   <= SP_CH;
                        state_reg  <= ST_DIV;
                        dv_rem_reg <= '0;
                        dv_cnt_reg <= 6'(DIV_W - 1);
                        dv_den_reg <= span_reg;
                        dv_quo_reg <= mag42(DIV_W'(prod_w));
                        dv_neg_reg <= prod_w[47];
                    end
                end

                default:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_reg       <= '{red: col_reg[0], green: col_reg[1],
                                           blue: col_reg[2], no_depth: nd_reg};
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> dv_den_reg != '0)
        else $error("divider running with zero divisor");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> {1'b0, dv_rem_reg} < {1'b0, dv_den_reg})
        else $error("partial remainder out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POST && step_reg == SP_CH) |-> span_reg != '0)
        else $error("channel interpolation with zero span");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_word.mode == MODE_MAP) |=> state_reg == ST_DIV)
        else $error("map word did not start the divider");

endmodule
